>>> hdl/scr_pkg.sv
`default_nettype none
package scr_pkg;

	localparam int GROUP_SIZE = 8;
	localparam int GIDX_W = 3;
	localparam logic [7:0] FLAG_MSB = 8'h80;

	typedef logic [GIDX_W-1:0] gidx_t;

	typedef struct packed {
		logic [GROUP_SIZE-1:0][7:0] bytes;
		logic [7:0]                 flags;
	} group_t;

endpackage
`default_nettype wire

>>> hdl/scr_ram.sv
`default_nettype none
module scr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule
`default_nettype wire

>>> hdl/scr_drain.sv
`default_nettype none
module scr_drain (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire scr_pkg::group_t grp,
	output logic                 free,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [7:0]           m_tdata,   // out_byte
	output logic [0:0]           m_tuser,   // is_flag
	output logic                 m_tlast    // last_of_group
);

	logic                              busy_q;
	logic                              flag_sent_q;
	logic [7:0]                        mask_q;
	logic [scr_pkg::GROUP_SIZE-1:0][7:0] bytes_q;
	scr_pkg::gidx_t                    idx;
	logic                              single;
	logic                              take;

	always_comb begin
		idx = '0;
		for (int i = scr_pkg::GROUP_SIZE - 1; i >= 0; i--) begin
			if (mask_q[7-i]) begin
				idx = scr_pkg::gidx_t'(i);
			end
		end
	end

	assign single   = (mask_q & (mask_q - 8'd1)) == 8'd0;
	assign m_tvalid = busy_q;
	assign m_tuser  = !flag_sent_q;
	assign m_tdata  = flag_sent_q ? bytes_q[idx] : mask_q;
	assign m_tlast  = flag_sent_q ? single : (mask_q == 8'd0);
	assign take     = m_tvalid && m_tready;
	assign free     = !busy_q || (take && m_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			flag_sent_q <= 1'b0;
			mask_q      <= '0;
		end else if (load) begin
			busy_q      <= 1'b1;
			flag_sent_q <= 1'b0;
			mask_q      <= grp.flags;
		end else if (take) begin
			flag_sent_q <= 1'b1;
			if (m_tlast) begin
				busy_q <= 1'b0;
			end
			if (flag_sent_q) begin
				mask_q <= mask_q & ~(scr_pkg::FLAG_MSB >> idx);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= grp.bytes;
		end
	end

endmodule
`default_nettype wire

>>> hdl/scanline_row_compressor.sv
`default_nettype none
// Channel   Direction  Signals                                Item
// s_        in         s_tvalid s_tready s_tdata s_tuser      one bitmap byte
// m_        out        m_tvalid m_tready m_tdata m_tuser m_tlast  flag or marked byte
// cfg_      in         cfg_valid cfg_ready cfg_data           row length write
//
// An input item is accepted each cycle; it reads the line store at acceptance
// and is compared in the following cycle, when the previous-row byte comes out of the RAM.
// A group that closes hands its flags and bytes to the drain buffer, which sends
// one output item a cycle while m_tready is high: flag byte, then marked bytes in column order.
// Input stalls only when a closing group finds the drain buffer still sending.
// Reset clears control state; the line store holds no data until a row is written.
module scanline_row_compressor #(
	parameter int MAX_ROW_BYTES = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // data_byte
	input  wire logic [0:0] s_tuser,   // new_bitmap
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // out_byte
	output logic [0:0]      m_tuser,   // is_flag
	output logic            m_tlast,   // last_of_group
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [8:0] cfg_data   // row_bytes
);

	localparam int CW = $clog2(MAX_ROW_BYTES);
	localparam int EW = (CW + 1 > 9) ? CW + 1 : 9;
	localparam logic [EW-1:0] MAX_EW = EW'(MAX_ROW_BYTES);

	logic [8:0]           row_bytes_q;
	logic [CW-1:0]        column_q;
	scr_pkg::gidx_t       group_count_q;
	logic                 first_row_q;

	logic                 valid_s1;
	logic [7:0]           data_s1;
	scr_pkg::gidx_t       gidx_s1;
	logic                 first_s1;
	logic                 close_s1;

	logic [7:0]                          asm_flags_q;
	logic [scr_pkg::GROUP_SIZE-1:0][7:0] asm_bytes_q;

	logic                 accept;
	logic                 new_bm;
	logic [CW-1:0]        col;
	scr_pkg::gidx_t       gidx;
	logic                 first;
	logic [EW-1:0]        rb_ext;
	logic [EW-1:0]        eff;
	logic [CW:0]          col_inc;
	logic                 row_end;
	logic                 full;
	logic [7:0]           prev_byte;
	logic                 differs;
	logic                 s2_go;
	logic                 drain_free;
	scr_pkg::group_t      grp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= 9'd2;
		end else if (cfg_valid && cfg_ready) begin
			row_bytes_q <= cfg_data;
		end
	end

	assign rb_ext = EW'(row_bytes_q);
	always_comb begin
		if (rb_ext == '0) begin
			eff = EW'(1);
		end else if (rb_ext > MAX_EW) begin
			eff = MAX_EW;
		end else begin
			eff = rb_ext;
		end
	end

	assign new_bm  = s_tuser[0];
	assign col     = new_bm ? '0 : column_q;
	assign gidx    = new_bm ? '0 : group_count_q;
	assign first   = new_bm || first_row_q;
	assign col_inc = {1'b0, col} + 1'b1;
	assign row_end = EW'(col_inc) >= eff;
	assign full    = gidx == scr_pkg::gidx_t'(scr_pkg::GROUP_SIZE - 1);

	assign s2_go    = valid_s1 && (!close_s1 || drain_free);
	assign s_tready = !valid_s1 || s2_go;
	assign accept   = s_tvalid && s_tready;

	scr_ram #(
		.WIDTH(8),
		.DEPTH(MAX_ROW_BYTES)
	) u_line (
		.clk  (clk),
		.we   (accept),
		.waddr(col),
		.wdata(s_tdata),
		.re   (accept),
		.raddr(col),
		.rdata(prev_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q      <= '0;
			group_count_q <= '0;
			first_row_q   <= 1'b1;
			valid_s1      <= 1'b0;
		end else begin
			if (accept) begin
				column_q      <= row_end ? '0 : CW'(col_inc);
				first_row_q   <= row_end ? 1'b0 : first;
				group_count_q <= (row_end || full) ? '0 : gidx + 1'b1;
				valid_s1      <= 1'b1;
			end else if (s2_go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1  <= s_tdata;
			gidx_s1  <= gidx;
			first_s1 <= first;
			close_s1 <= row_end || full;
		end
	end

	assign differs = first_s1 || (data_s1 != prev_byte);

	always_comb begin
		grp.bytes          = asm_bytes_q;
		grp.bytes[gidx_s1] = data_s1;
		grp.flags          = (gidx_s1 == '0) ? 8'd0 : asm_flags_q;
		if (differs) begin
			grp.flags = grp.flags | (scr_pkg::FLAG_MSB >> gidx_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asm_flags_q <= '0;
		end else if (s2_go) begin
			asm_flags_q <= grp.flags;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			asm_bytes_q <= grp.bytes;
		end
	end

	scr_drain u_drain (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (s2_go && close_s1),
		.grp     (grp),
		.free    (drain_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_go && close_s1) |-> drain_free)
		else $error("group handed to a busy drain buffer");

	a_flag_then_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tuser[0] && !m_tlast) |=> (m_tvalid && !m_tuser[0]))
		else $error("flag with marked bytes not followed by a data item");

	a_new_bitmap_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && new_bm) |=> (gidx_s1 == '0 && first_s1 && valid_s1))
		else $error("new bitmap did not restart the group");

endmodule
`default_nettype wire
